### design/frcv_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Shared constants, request codes and payload types for the checksummed
// frame receiver.
// ----------------------------------------------------------------------------
package frcv_pkg;

	// Result store geometry.
	localparam int RESULT_DEPTH = 64;
	localparam int ADDR_W       = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
	localparam int CNT_W        = $clog2(RESULT_DEPTH + 1);

	// Fixed field widths of the channels.
	localparam int IDX_W   = 6;
	localparam int SCNT_W  = 7;
	localparam int WORD_W  = 32;
	localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	// Header bytes.
	localparam logic [7:0] HDR_PLAIN = 8'hFF;
	localparam logic [7:0] HDR_ACK   = 8'h43;

	// Frame position codes.
	localparam logic [2:0] POS_IDLE      = 3'd0;
	localparam logic [2:0] POS_FIRST     = 3'd1;
	localparam logic [2:0] POS_LAST_DATA = 3'd4;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_BYTE    = 2'd0,
		REQ_RESTART = 2'd1,
		REQ_READ    = 2'd2,
		REQ_CLR_ACK = 2'd3
	} req_t;

	// Input transaction payload.
	typedef struct packed {
		req_t               req_type;
		logic [7:0]         rx_byte;
		logic [IDX_W-1:0]   read_index;
	} in_t;

	// Output transaction payload.
	typedef struct packed {
		logic               frame_done;
		logic [WORD_W-1:0]  frame_value;
		logic               checksum_error;
		logic [SCNT_W-1:0]  stored_count;
		logic               ack_seen;
		logic [WORD_W-1:0]  read_value;
		logic               read_valid;
	} out_t;

endpackage

### design/frcv_in_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one request per transaction.
// ----------------------------------------------------------------------------
interface frcv_in_if;
	import frcv_pkg::*;

	logic valid;
	logic ready;
	in_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/frcv_out_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface frcv_out_if;
	import frcv_pkg::*;

	logic valid;
	logic ready;
	out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/checksummed_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// Checksummed frame receiver
// Assembles checksummed count frames from a byte stream and keeps the good
// counts in a result store that can be read back by index.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake     | Payload
//  --------+-----------+---------------+-------------------------------------
//  req     | in        | valid / ready | req_type, rx_byte, read_index
//  rsp     | out       | valid / ready | frame_done, frame_value,
//          |           |               | checksum_error, stored_count,
//          |           |               | ack_seen, read_value, read_valid
//
//  Every request yields exactly one result, through stage one and the
//  output register. A new request is accepted every cycle as long as
//  results are taken. Frame state and the store write are resolved in
//  the acceptance cycle; the registered store read data lands in stage one.
//  A stalled result waits in the output register while stage one still
//  fills, so ready drops only when both are occupied.
//  Reset clears the frame state, the count and the acknowledge flag; the
//  store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver_top (
	input  logic            clk,
	input  logic            arst_n,
	frcv_in_if.sink         req,
	frcv_out_if.source      rsp
);
	import frcv_pkg::*;

	// Frame and count state.
	logic [2:0]        pos_q, pos_d;
	logic              hdr_ack_q, hdr_ack_d;
	logic [WORD_W-1:0] shift_q, shift_d;
	logic [7:0]        sum_q, sum_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              ack_q, ack_d;

	// Per-transaction results computed at acceptance.
	logic              done_c;
	logic [WORD_W-1:0] value_c;
	logic              err_c;
	logic              rd_hit_c;
	logic              we_c;

	// Pipeline registers.
	logic              valid_s1;
	logic              done_s1;
	logic [WORD_W-1:0] value_s1;
	logic              err_s1;
	logic [SCNT_W-1:0] scnt_s1;
	logic              ack_s1;
	logic              rd_s1;
	logic [WORD_W-1:0] ram_rdata;
	logic              out_valid_q;
	out_t              out_q;

	logic accept;
	logic s1_adv;

	assign s1_adv    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_adv;
	assign accept    = req.valid && req.ready;

	// Next-state logic for one request.
	always_comb begin
		pos_d     = pos_q;
		hdr_ack_d = hdr_ack_q;
		shift_d   = shift_q;
		sum_d     = sum_q;
		count_d   = count_q;
		ack_d     = ack_q;
		done_c    = 1'b0;
		value_c   = '0;
		err_c     = 1'b0;
		rd_hit_c  = 1'b0;
		we_c      = 1'b0;
		unique case (req.data.req_type)
			REQ_BYTE: begin
				if (pos_q == POS_IDLE) begin
					if (req.data.rx_byte == HDR_PLAIN || req.data.rx_byte == HDR_ACK) begin
						hdr_ack_d = (req.data.rx_byte == HDR_ACK);
						shift_d   = '0;
						sum_d     = '0;
						pos_d     = POS_FIRST;
					end
				end else begin
					if (hdr_ack_q) begin
						ack_d = 1'b1;
					end
					if (pos_q <= POS_LAST_DATA) begin
						shift_d = {shift_q[WORD_W-9:0], req.data.rx_byte};
						sum_d   = sum_q + req.data.rx_byte;
						pos_d   = pos_q + 3'd1;
					end else begin
						// Checksum byte closes the frame.
						if (req.data.rx_byte == sum_q) begin
							done_c  = 1'b1;
							value_c = shift_q;
							if (count_q < CNT_W'(RESULT_DEPTH)) begin
								we_c    = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
						end else begin
							err_c = 1'b1;
						end
						pos_d = POS_IDLE;
					end
				end
			end
			REQ_RESTART: begin
				pos_d   = POS_IDLE;
				count_d = '0;
			end
			REQ_READ: begin
				rd_hit_c = CMP_W'(req.data.read_index) < CMP_W'(count_q);
			end
			REQ_CLR_ACK: begin
				ack_d = 1'b0;
			end
			default: begin
				ack_d = ack_q;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_IDLE;
			hdr_ack_q <= 1'b0;
			shift_q   <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			ack_q     <= 1'b0;
		end else if (accept) begin
			pos_q     <= pos_d;
			hdr_ack_q <= hdr_ack_d;
			shift_q   <= shift_d;
			sum_q     <= sum_d;
			count_q   <= count_d;
			ack_q     <= ack_d;
		end
	end

	// Result store; the read issued at acceptance lands in stage one.
	frcv_ram #(
		.WIDTH (WORD_W),
		.DEPTH (RESULT_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && we_c),
		.waddr (ADDR_W'(count_q)),
		.wdata (shift_q),
		.re    (accept),
		.raddr (ADDR_W'(req.data.read_index)),
		.rdata (ram_rdata)
	);

	// Stage one: request results beside the store read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			done_s1  <= done_c;
			value_s1 <= value_c;
			err_s1   <= err_c;
			scnt_s1  <= SCNT_W'(count_d);
			ack_s1   <= ack_d;
			rd_s1    <= rd_hit_c;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.frame_done     <= done_s1;
			out_q.frame_value    <= value_s1;
			out_q.checksum_error <= err_s1;
			out_q.stored_count   <= scnt_s1;
			out_q.ack_seen       <= ack_s1;
			out_q.read_value     <= rd_s1 ? ram_rdata : '0;
			out_q.read_valid     <= rd_s1;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

### design/frcv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frcv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds when not enabled.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/frcv_checker.sv
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Concurrent checks on the ports of the frame receiver top level.
// ----------------------------------------------------------------------------
module frcv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        frame_done,
	input logic [31:0] frame_value,
	input logic        checksum_error,
	input logic        read_valid,
	input logic [31:0] read_value
);

	// A frame closes either good or bad, never both.
	a_done_xor_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_done && checksum_error))
		else $error("frame_done and checksum_error both set");

	// A read result never comes with a frame result.
	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> !frame_done && !checksum_error)
		else $error("read result mixed with frame result");

	// Values are zero when their flags are clear.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> frame_value == 32'd0)
		else $error("frame_value set without frame_done");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_value == 32'd0)
		else $error("read_value set without read_valid");

	// A stalled transaction keeps its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_value)
			&& $stable(read_value))
		else $error("result changed while stalled");

endmodule

bind checksummed_frame_receiver_top frcv_checker u_frcv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.frame_done     (rsp.data.frame_done),
	.frame_value    (rsp.data.frame_value),
	.checksum_error (rsp.data.checksum_error),
	.read_valid     (rsp.data.read_valid),
	.read_value     (rsp.data.read_value)
);

### sim/frcv_checker.sv
// ----------------------------------------------------------------------------
// Frame receiver checker
// Watches the request and result channels of the frame receiver. It keeps
// its own model of the frame state, the result store and the acknowledge
// flag, predicts one result per accepted request and compares every
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module frcv_tb_checker (
	input  logic clk,
	input  logic arst_n,
	frcv_in_if   req,
	frcv_out_if  rsp,
	output int   error_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import frcv_pkg::*;

	// Model of the receiver state.
	logic [2:0]        frame_pos;
	logic              frame_is_ack;
	logic [31:0]       frame_bytes;
	logic [7:0]        frame_sum;
	logic [31:0]       count_store [RESULT_DEPTH];
	logic [CNT_W-1:0]  count_fill;
	logic              ack_sticky;

	// Predicted results, oldest first.
	out_t expected_results [$];

	initial begin
		error_count = 0;
		pending     = 0;
	end

	// Prints one mismatch line and counts it.
	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns frcv_checker: %s got 0x%0h, want 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Applies one request to the model and returns the result it causes.
	function automatic out_t decode_request(input in_t it);
		out_t r;
		r = '0;
		case (it.req_type)
			REQ_BYTE: begin
				if (frame_pos == POS_IDLE) begin
					// Only a header byte opens a frame; anything else is ignored.
					if (it.rx_byte == HDR_PLAIN || it.rx_byte == HDR_ACK) begin
						frame_is_ack = (it.rx_byte == HDR_ACK);
						frame_bytes  = '0;
						frame_sum    = '0;
						frame_pos    = POS_FIRST;
					end
				end else begin
					if (frame_is_ack)
						ack_sticky = 1'b1;
					if (frame_pos <= POS_LAST_DATA) begin
						frame_bytes = {frame_bytes[23:0], it.rx_byte};
						frame_sum   = frame_sum + it.rx_byte;
						frame_pos   = frame_pos + 3'd1;
					end else begin
						// Checksum byte: a good frame is reported even when the store is full.
						if (it.rx_byte == frame_sum) begin
							r.frame_done  = 1'b1;
							r.frame_value = frame_bytes;
							if (count_fill < RESULT_DEPTH) begin
								count_store[count_fill[ADDR_W-1:0]] = frame_bytes;
								count_fill = count_fill + 1'b1;
							end
						end else begin
							r.checksum_error = 1'b1;
						end
						frame_pos = POS_IDLE;
					end
				end
			end
			REQ_RESTART: begin
				frame_pos  = POS_IDLE;
				count_fill = '0;
			end
			REQ_READ: begin
				if (it.read_index < count_fill) begin
					r.read_value = count_store[it.read_index];
					r.read_valid = 1'b1;
				end
			end
			default: begin
				ack_sticky = 1'b0;
			end
		endcase
		r.stored_count = count_fill;
		r.ack_seen     = ack_sticky;
		return r;
	endfunction

	// Checks results first, then predicts for the request of the same edge.
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		out_t got;
		if (!arst_n) begin
			frame_pos    = POS_IDLE;
			frame_is_ack = 1'b0;
			frame_bytes  = '0;
			frame_sum    = '0;
			count_fill   = '0;
			ack_sticky   = 1'b0;
			expected_results.delete();
			pending      = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (expected_results.size() == 0) begin
					report("unexpected result transaction", 32'd0, 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (got.frame_done !== want.frame_done)
						report("frame_done", 32'(got.frame_done), 32'(want.frame_done));
					if (got.frame_value !== want.frame_value)
						report("frame_value", got.frame_value, want.frame_value);
					if (got.checksum_error !== want.checksum_error)
						report("checksum_error", 32'(got.checksum_error),
							32'(want.checksum_error));
					if (got.stored_count !== want.stored_count)
						report("stored_count", 32'(got.stored_count),
							32'(want.stored_count));
					if (got.ack_seen !== want.ack_seen)
						report("ack_seen", 32'(got.ack_seen), 32'(want.ack_seen));
					if (got.read_value !== want.read_value)
						report("read_value", got.read_value, want.read_value);
					if (got.read_valid !== want.read_valid)
						report("read_valid", 32'(got.read_valid), 32'(want.read_valid));
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(decode_request(req.data));
			pending = expected_results.size();
		end
	end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Drives request transactions into the checksummed frame receiver: a short
// directed run over headers, checksums, reads and flag handling, then random
// frames mixed with reads, restarts, flag clears and noise bytes. The sender
// works in bursts and the receiver stalls in changing patterns. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import frcv_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;
	int   error_count;
	int   pending;
	int   items_sent;
	int   burst_left;
	int   cycles;
	int   stall_mode;
	int   stall_left;
	int   stall_phase;

	frcv_in_if  req_ch ();
	frcv_out_if rsp_ch ();

	checksummed_frame_receiver_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	frcv_tb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.error_count (error_count),
		.pending     (pending)
	);

	// Clock with a 2 ns period.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Result side: ready follows one pattern for a while, then switches.
	initial begin
		stall_mode  = 0;
		stall_left  = 0;
		stall_phase = 0;
	end
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 300);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0:       rsp_ch.ready <= 1'b1;
			1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
			2:       rsp_ch.ready <= ($urandom_range(0, 4) == 0);
			default: rsp_ch.ready <= ((stall_phase % 7) < 3);
		endcase
	end

	// Low 8 bits of the sum of the four bytes of a count.
	function automatic logic [7:0] sum_of(input logic [31:0] v);
		return v[31:24] + v[23:16] + v[15:8] + v[7:0];
	endfunction

	// Random byte with a lean toward the header values and the extremes.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 11))
			0:       return 8'h00;
			1:       return HDR_PLAIN;
			2:       return HDR_ACK;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Sends one request transaction; unused fields carry random bits.
	task automatic put(input req_t r, input logic [7:0] b, input logic [5:0] idx,
			input bit counted);
		in_t it;
		int  gap;
		it.req_type   = r;
		it.rx_byte    = b;
		it.read_index = idx;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk) req_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (counted)
			items_sent++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		put(REQ_BYTE, b, 6'($urandom_range(0, 63)), 1'b1);
	endtask

	task automatic put_cmd(input req_t r, input logic [5:0] idx);
		put(r, 8'($urandom_range(0, 255)), idx, 1'b1);
	endtask

	// Sends a whole frame; reads and flag clears may fall between its bytes.
	task automatic put_frame(input logic [7:0] hdr, input logic [31:0] value,
			input logic [7:0] cs, input bit interleave);
		logic [7:0] bytes [6];
		bytes[0] = hdr;
		bytes[1] = value[31:24];
		bytes[2] = value[23:16];
		bytes[3] = value[15:8];
		bytes[4] = value[7:0];
		bytes[5] = cs;
		for (int i = 0; i < 6; i++) begin
			if (interleave && i > 0 && $urandom_range(0, 2) == 0)
				put_cmd($urandom_range(0, 1) ? REQ_READ : REQ_CLR_ACK,
					6'($urandom_range(0, 63)));
			put_byte(bytes[i]);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		logic [31:0] v;
		logic [7:0]  hdr;
		int          k;
		int          n;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		items_sent   = 0;
		burst_left   = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: extreme counts, both headers, a bad checksum, reads and flags.
		put_byte(8'h00);
		put_frame(HDR_PLAIN, 32'h0000_0000, 8'h00, 1'b0);
		put_frame(HDR_ACK, 32'hFFFF_FFFF, sum_of(32'hFFFF_FFFF), 1'b0);
		put_cmd(REQ_READ, 6'd0);
		put_cmd(REQ_READ, 6'd1);
		put_cmd(REQ_READ, 6'd63);
		put_cmd(REQ_CLR_ACK, 6'd63);
		put_frame(HDR_PLAIN, 32'h1234_5678, 8'h00, 1'b0);
		put_byte(HDR_ACK);
		put_byte(8'h43);
		put_cmd(REQ_RESTART, 6'd0);
		put_cmd(REQ_READ, 6'd0);

		// Random: mostly well-formed frames, with broken frames and commands.
		while (items_sent < RANDOM_ITEMS) begin
			hdr = $urandom_range(0, 1) ? HDR_PLAIN : HDR_ACK;
			if ($urandom_range(0, 199) == 0) begin
				// Restart, sometimes in the middle of a frame.
				if ($urandom_range(0, 1)) begin
					put_byte(hdr);
					n = $urandom_range(0, 4);
					for (int i = 0; i < n; i++)
						put_byte(pick_byte());
				end
				put_cmd(REQ_RESTART, 6'($urandom_range(0, 63)));
			end else begin
				k = $urandom_range(0, 99);
				v = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
				if (k < 58) begin
					put_frame(hdr, v, sum_of(v), $urandom_range(0, 3) == 0);
				end else if (k < 70) begin
					put_frame(hdr, v, sum_of(v) ^ 8'($urandom_range(1, 255)),
						$urandom_range(0, 3) == 0);
				end else if (k < 84) begin
					n = $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						put_cmd(REQ_READ, 6'($urandom_range(0, 63)));
				end else if (k < 90) begin
					put_cmd(REQ_CLR_ACK, 6'($urandom_range(0, 63)));
				end else begin
					// Idle noise: never a header byte, so it is ignored.
					v[7:0] = pick_byte();
					if (v[7:0] == HDR_PLAIN || v[7:0] == HDR_ACK)
						v[7:0] = v[7:0] ^ 8'h01;
					put(REQ_BYTE, v[7:0], 6'($urandom_range(0, 63)), 1'b0);
				end
			end
		end
		@(negedge clk) req_ch.valid <= 1'b0;

		// Drain, then keep watching for any stray result before the verdict.
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### filelist.f
design/frcv_pkg.sv
design/frcv_in_if.sv
design/frcv_out_if.sv
design/frcv_ram.sv
design/checksummed_frame_receiver_top.sv
design/frcv_checker.sv
sim/frcv_checker.sv
sim/tb_top.sv
